FILE: rtl/core/wpm_pkg.sv
// Shared constants, operation codes and control types of the wildcard pattern matcher.
package wpm_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 64;
    localparam int unsigned OP_W = 2;
    localparam int unsigned SYM_W = 8;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND  = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd2;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_ANY  = 8'h3F;

    typedef struct packed {
        logic start;
        logic rd;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic last_addr;
    } t_sts;

endpackage

FILE: rtl/core/wpm_ifs.sv
// Valid/ready channel interfaces for the input items and the result items.
interface wpm_in_if import wpm_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [SYM_W-1:0] symbol;

    modport source(output valid, operation, symbol, input ready);
    modport sink(input valid, operation, symbol, output ready);
endinterface

interface wpm_out_if;
    logic valid;
    logic ready;
    logic full_match;
    logic pattern_overflow;

    modport source(output valid, full_match, pattern_overflow, input ready);
    modport sink(input valid, full_match, pattern_overflow, output ready);
endinterface

FILE: rtl/core/wpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wpm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/wpm_ctrl.sv
// Controller state machine: accepts an item, runs the row sweep and hands over the result.
module wpm_ctrl import wpm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_in_op,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  t_sts            i_sts,
    output t_cmd            o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_ovalid;
    logic       n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    // An append always leaves a non-empty pattern to sweep.
                    if (i_in_op == OP_APPEND || (i_in_op != OP_CLEAR && !i_sts.len_zero)) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RUN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

FILE: rtl/core/wpm_dp.sv
// Datapath: pattern store, match row store and the serial match-bit update.
module wpm_dp import wpm_pkg::*; #(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [OP_W-1:0]  i_op,
    input  logic [SYM_W-1:0] i_symbol,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic             o_full_match,
    output logic             o_pattern_overflow
);

    localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

    logic [LW-1:0]    r_len;
    logic             r_ovf;
    logic             r_row0;
    logic             r_left;
    logic             r_diag;
    logic             r_text;
    logic [SYM_W-1:0] r_sym;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_widx;
    logic             r_pend;
    logic             r_o_match;
    logic             r_o_ovf;

    logic             full;
    logic             pat_we;
    logic [SYM_W-1:0] pat_rdata;
    logic             row_rdata;
    logic             nb;

    assign full   = (r_len == LW'(MAX_PATTERN));
    assign pat_we = i_cmd.start && (i_op == OP_APPEND) && !full;

    wpm_ram #(
        .WIDTH(SYM_W),
        .DEPTH(MAX_PATTERN)
    ) u_pat_ram (
        .i_clk  (i_clk),
        .i_we   (pat_we),
        .i_waddr(r_len[AW-1:0]),
        .i_wdata(i_symbol),
        .i_re   (i_cmd.rd),
        .i_raddr(r_idx),
        .o_rdata(pat_rdata)
    );

    // Entry j holds match bit j+1; bit zero lives in r_row0.
    wpm_ram #(
        .WIDTH(1),
        .DEPTH(MAX_PATTERN)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (r_pend),
        .i_waddr(r_widx),
        .i_wdata(nb),
        .i_re   (i_cmd.rd),
        .i_raddr(r_idx),
        .o_rdata(row_rdata)
    );

    // r_left is the new bit k-1 and r_diag the old bit k-1 of the row.
    always_comb begin
        if (r_text) begin
            if (pat_rdata == SYM_STAR) begin
                nb = r_left | row_rdata;
            end else if (pat_rdata == SYM_ANY || pat_rdata == r_sym) begin
                nb = r_diag;
            end else begin
                nb = 1'b0;
            end
        end else begin
            nb = r_left & (pat_rdata == SYM_STAR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_row0 <= 1'b1;
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd;
            if (i_cmd.start) begin
                r_idx <= '0;
                case (i_op)
                    OP_CLEAR: begin
                        r_len  <= '0;
                        r_ovf  <= 1'b0;
                        r_row0 <= 1'b1;
                    end
                    OP_APPEND: begin
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_len <= r_len + LW'(1);
                        end
                        r_row0 <= 1'b1;
                    end
                    OP_TEXT: begin
                        r_row0 <= 1'b0;
                    end
                    default: begin
                        r_row0 <= 1'b1;
                    end
                endcase
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_text <= (i_op == OP_TEXT);
            r_left <= (i_op != OP_TEXT);
            r_diag <= r_row0;
            r_sym  <= i_symbol;
        end else if (r_pend) begin
            r_left <= nb;
            r_diag <= row_rdata;
        end
        if (i_cmd.rd) begin
            r_widx <= r_idx;
        end
        if (i_cmd.load) begin
            r_o_match <= r_left;
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_sts.len_zero  = (r_len == '0);
    assign o_sts.last_addr = ((LW'(r_idx) + LW'(1)) == r_len);

    assign o_full_match       = r_o_match;
    assign o_pattern_overflow = r_o_ovf;

endmodule

FILE: rtl/core/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: controller, datapath and checks.
//
//  Channel | Direction | Payload                          | Transfer
//  i_in    | in        | operation[1:0], symbol[7:0]      | valid & ready
//  o_out   | out       | full_match, pattern_overflow     | valid & ready
//
// A text, restart or append item sweeps the L pattern positions, L being the length
// after the item, one per cycle over the single read port of the pattern and row
// memories, then the drain and finish states; a clear, or any item that leaves the
// pattern empty, goes straight to the finish state. Reset leaves an empty pattern
// and no overflow. A result waiting in the output register does not hold off the
// next item; only the hand-over of the following result waits for it to be taken.
module wildcard_pattern_matcher import wpm_pkg::*; #(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wpm_in_if.sink            i_in,
    wpm_out_if.source         o_out
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    wpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.operation),
        .o_in_ready (in_ready),
        .i_out_ready(o_out.ready),
        .o_out_valid(o_out.valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wpm_dp #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (i_in.operation),
        .i_symbol          (i_in.symbol),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_full_match      (o_out.full_match),
        .o_pattern_overflow(o_out.pattern_overflow)
    );

    assign i_in.ready = in_ready;

`ifndef NO_ASSERTIONS
    // A new result must never overwrite one that is still waiting for its transfer.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten while still pending");

    // The sweep only runs over a non-empty pattern.
    a_sweep_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd |-> !sts.len_zero)
        else $error("row sweep started on an empty pattern");

    // A clear leaves an empty pattern behind.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready && i_in.operation == OP_CLEAR) |=> sts.len_zero)
        else $error("pattern length not cleared");

    // No input item is taken while a sweep is in progress.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd |-> !in_ready)
        else $error("input accepted during row sweep");
`endif

endmodule

FILE: tb/wpm_match_checker.sv
// Scoreboard for the wildcard pattern matcher: predicts each result and compares it.
module wpm_match_checker import wpm_pkg::*; #(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wpm_in_if    i_in,
    wpm_out_if   i_out,
    output int   o_fail_count,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic full_match;
        logic pattern_overflow;
    } t_match_outcome;

    logic [SYM_W-1:0]     pat_sym [MAX_PATTERN];
    int unsigned          pat_len;
    logic [MAX_PATTERN:0] prefix_row;
    logic                 overflow_seen;
    t_match_outcome       awaited_q [$];

    // Row for empty text: only leading stars can match nothing.
    function automatic void rebuild_empty_row();
        prefix_row = '0;
        prefix_row[0] = 1'b1;
        for (int unsigned k = 1; k <= pat_len; k++) begin
            prefix_row[k] = prefix_row[k-1] && (pat_sym[k-1] == SYM_STAR);
        end
    endfunction

    function automatic t_match_outcome apply_item(input logic [OP_W-1:0] op,
                                                  input logic [SYM_W-1:0] sym);
        t_match_outcome       outcome;
        logic [MAX_PATTERN:0] next_row;
        next_row = prefix_row;
        case (op)
            OP_CLEAR: begin
                pat_len = 0;
                overflow_seen = 1'b0;
                rebuild_empty_row();
            end
            OP_APPEND: begin
                if (pat_len < MAX_PATTERN) begin
                    pat_sym[pat_len] = sym;
                    pat_len++;
                end else begin
                    overflow_seen = 1'b1;
                end
                rebuild_empty_row();
            end
            OP_TEXT: begin
                // A star extends either the new row to its left or the old row above it.
                next_row[0] = 1'b0;
                for (int unsigned k = 1; k <= pat_len; k++) begin
                    if (pat_sym[k-1] == SYM_STAR) begin
                        next_row[k] = next_row[k-1] | prefix_row[k];
                    end else if (pat_sym[k-1] == SYM_ANY || pat_sym[k-1] == sym) begin
                        next_row[k] = prefix_row[k-1];
                    end else begin
                        next_row[k] = 1'b0;
                    end
                end
                prefix_row = next_row;
            end
            default: begin
                rebuild_empty_row();
            end
        endcase
        outcome.full_match = prefix_row[pat_len];
        outcome.pattern_overflow = overflow_seen;
        return outcome;
    endfunction

    initial begin
        o_fail_count = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin : watch
        t_match_outcome got;
        t_match_outcome want;
        if (!i_rst_n) begin
            pat_len = 0;
            overflow_seen = 1'b0;
            rebuild_empty_row();
            awaited_q.delete();
        end else begin
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                got.full_match = i_out.full_match;
                got.pattern_overflow = i_out.pattern_overflow;
                if (awaited_q.size() == 0) begin
                    $error("result transfer with no item awaiting one");
                    o_fail_count++;
                end else begin
                    want = awaited_q.pop_front();
                    if (got.full_match !== want.full_match) begin
                        $error("full_match mismatch: expected %0b, got %0b",
                               want.full_match, got.full_match);
                        o_fail_count++;
                    end
                    if (got.pattern_overflow !== want.pattern_overflow) begin
                        $error("pattern_overflow mismatch: expected %0b, got %0b",
                               want.pattern_overflow, got.pattern_overflow);
                        o_fail_count++;
                    end
                end
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                awaited_q.push_back(apply_item(i_in.operation, i_in.symbol));
            end
        end
        o_outstanding = awaited_q.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the wildcard pattern matcher testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wpm_pkg::*;

    localparam int unsigned TOTAL_ITEMS   = 1900;
    localparam int unsigned HOLD_AT       = 500;
    localparam int unsigned DRAIN_AT      = 1100;
    localparam int unsigned CALM_FROM     = 1600;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned SETTLE_CYCLES = MAX_PATTERN_DEF + 16;
    localparam logic [SYM_W-1:0] CH_A = 8'h61;
    localparam logic [SYM_W-1:0] CH_B = 8'h62;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wpm_in_if  in_ch ();
    wpm_out_if out_ch ();

    int fail_count;
    int outstanding;

    int unsigned      items_sent;
    bit               calm;
    bit               hold_req;
    bit               hold_done;
    bit               drain_done;
    logic [SYM_W-1:0] pattern_q [$];

    always #5 i_clk = ~i_clk;

    wildcard_pattern_matcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    wpm_match_checker checker_u (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Offers one item, waits for its transfer and keeps a copy of the stored pattern.
    task automatic offer_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
        if (op == OP_CLEAR) begin
            pattern_q.delete();
        end else if (op == OP_APPEND && pattern_q.size() < MAX_PATTERN_DEF) begin
            pattern_q.push_back(sym);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.symbol <= sym;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        calm = (items_sent >= CALM_FROM);
        if (!calm && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [SYM_W-1:0] random_text_symbol();
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom);
        end
        return CH_A + 8'($urandom_range(0, 2));
    endfunction

    function automatic logic [SYM_W-1:0] random_pattern_symbol();
        case ($urandom_range(0, 9))
            0, 1:    return SYM_STAR;
            2, 3:    return SYM_ANY;
            8:       return 8'($urandom);
            default: return CH_A + 8'($urandom_range(0, 2));
        endcase
    endfunction

    // A pattern, then a few texts built mostly to match it, some of them spoilt.
    task automatic run_sequence(input bit force_long);
        logic [SYM_W-1:0] text_q [$];
        int unsigned      n_append;
        if (force_long || $urandom_range(0, 4) != 0) begin
            offer_item(OP_CLEAR, 8'($urandom));
        end
        if (force_long) begin
            n_append = MAX_PATTERN_DEF + 2;
        end else if ($urandom_range(0, 19) == 0) begin
            n_append = $urandom_range(40, 70);
        end else begin
            n_append = $urandom_range(0, 6);
        end
        repeat (n_append) offer_item(OP_APPEND, random_pattern_symbol());
        repeat ($urandom_range(1, 3)) begin
            text_q.delete();
            if ($urandom_range(0, 3) != 0) begin
                foreach (pattern_q[k]) begin
                    if (pattern_q[k] == SYM_STAR) begin
                        repeat ($urandom_range(0, 2)) text_q.push_back(random_text_symbol());
                    end else if (pattern_q[k] == SYM_ANY) begin
                        text_q.push_back(8'($urandom));
                    end else begin
                        text_q.push_back(pattern_q[k]);
                    end
                end
                if (text_q.size() != 0 && $urandom_range(0, 2) == 0) begin
                    text_q[$urandom_range(0, text_q.size() - 1)] = random_text_symbol();
                end else if ($urandom_range(0, 5) == 0) begin
                    text_q.push_back(random_text_symbol());
                end
            end else begin
                repeat ($urandom_range(0, 8)) text_q.push_back(random_text_symbol());
            end
            foreach (text_q[k]) offer_item(OP_TEXT, text_q[k]);
            if ($urandom_range(0, 2) != 0) begin
                offer_item(OP_RESTART, 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        in_ch.valid = 1'b0;
        in_ch.operation = OP_CLEAR;
        in_ch.symbol = '0;
        items_sent = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        drain_done = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pattern: matches only the empty text.
        offer_item(OP_TEXT, CH_A);
        offer_item(OP_RESTART, 8'hFF);
        // A lone star swallows anything; an append restarts the text.
        offer_item(OP_APPEND, SYM_STAR);
        offer_item(OP_TEXT, 8'h00);
        offer_item(OP_TEXT, 8'hFF);
        offer_item(OP_APPEND, SYM_ANY);
        offer_item(OP_TEXT, 8'h80);
        offer_item(OP_TEXT, 8'h7F);
        offer_item(OP_APPEND, CH_A);
        offer_item(OP_TEXT, CH_B);
        offer_item(OP_TEXT, CH_A);
        offer_item(OP_TEXT, CH_A);
        offer_item(OP_RESTART, 8'h00);
        // Literal bytes at both ends of the range.
        offer_item(OP_CLEAR, 8'hFF);
        offer_item(OP_APPEND, 8'hFF);
        offer_item(OP_TEXT, 8'hFF);
        offer_item(OP_TEXT, 8'hFF);
        offer_item(OP_RESTART, 8'h55);
        offer_item(OP_APPEND, 8'h00);
        offer_item(OP_TEXT, 8'hFF);
        offer_item(OP_TEXT, 8'h00);
        offer_item(OP_CLEAR, 8'h00);

        // Fill the pattern past its capacity so that symbols are dropped.
        run_sequence(1'b1);

        while (items_sent < TOTAL_ITEMS) begin
            if (!hold_req && items_sent >= HOLD_AT) begin
                hold_req = 1'b1;
            end
            if (!drain_done && items_sent >= DRAIN_AT) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                while (outstanding != 0) @(negedge i_clk);
                drain_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 3) begin
                repeat ($urandom_range(1, 3)) begin
                    offer_item(OP_W'($urandom_range(0, 3)), 8'($urandom));
                end
            end
            run_sequence(1'b0);
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off so that the input backs up.
    initial begin : result_taker
        int unsigned held;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                held = 1;
                while (held < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(20, 80) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/wpm_pkg.sv
rtl/core/wpm_ifs.sv
rtl/core/wpm_ram.sv
rtl/core/wpm_ctrl.sv
rtl/core/wpm_dp.sv
rtl/core/wildcard_pattern_matcher.sv
tb/wpm_match_checker.sv
tb/testbench.sv
